// ----- rtl/assert_macros.svh -----
// Assertion macros used by the datapath RTL of the periodic task timer table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define PTT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be true outside reset.
`define PTT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PTT_ASSERT(lbl, clk, rstn, prop, msg)
`define PTT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/ptt_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package ptt_pkg;

    // Sizes
    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DISP_CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int IN_W        = 40;
    localparam int OUT_W       = 8;

    // Millisecond to tick conversion: floor(p / 1000) = (p * RECIP_MUL) >> RECIP_SHIFT
    localparam int MS_PER_SEC  = 1000;
    localparam int RECIP_SHIFT = 41;
    localparam longint unsigned RECIP_MUL_L =
        ((64'd1 << RECIP_SHIFT) + MS_PER_SEC - 1) / MS_PER_SEC;
    localparam logic [31:0] RECIP_MUL = 32'(RECIP_MUL_L);
    localparam logic [15:0] TPS_RESET = 16'(MS_PER_SEC);

    // Operation codes
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_ENABLE   = 3'd2;
    localparam logic [2:0] OP_DISABLE  = 3'd3;
    localparam logic [2:0] OP_SETP     = 3'd4;
    localparam logic [2:0] OP_DISPATCH = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_NOSLOT = 2'd3;

    // Slot walker load sources
    localparam logic [1:0] WSRC_ZERO  = 2'd0;
    localparam logic [1:0] WSRC_COUNT = 2'd1;
    localparam logic [1:0] WSRC_IDX   = 2'd2;

    // Result slot sources
    localparam logic [1:0] SLOT_ZERO = 2'd0;
    localparam logic [1:0] SLOT_IDX  = 2'd1;
    localparam logic [1:0] SLOT_WALK = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       item_load;
        logic       walk_load;
        logic [1:0] walk_src;
        logic       walk_inc;
        logic       tick_step;
        logic       conv_period;
        logic       delay_cap;
        logic       add_wr;
        logic       per_wr;
        logic       en_set;
        logic       en_clr;
        logic       disp_wr;
        logic       out_load;
        logic [1:0] out_status;
        logic [1:0] out_slot_sel;
        logic       out_disp;
        logic       out_last;
    } ptt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       idx_bad;
        logic       walk_end;
        logic       hit;
        logic       more_hits;
        logic       tick_done;
        logic       out_free;
    } ptt_stat_t;

endpackage

// ----- rtl/ptt_ms2tick.sv -----
// Two-stage millisecond to tick converter: (ms * tick_rate) / 1000, low 16 bits.
module ptt_ms2tick (
    input  logic        clk,
    input  logic [15:0] ms,
    input  logic [15:0] tps,
    output logic [15:0] ticks
);

    logic [31:0] prod_reg;
    logic [63:0] scaled;
    logic [15:0] q_reg;

    // Scale by the reciprocal of 1000 and keep the low 16 bits of the quotient
    assign scaled = prod_reg * ptt_pkg::RECIP_MUL;

    always_ff @(posedge clk)
    begin
        prod_reg <= ms * tps;
        q_reg    <= scaled[ptt_pkg::RECIP_SHIFT +: 16];
    end

    assign ticks = q_reg;

endmodule

// ----- rtl/ptt_dpath.sv -----
// Datapath: slot tables, item and config registers, converter and result register.
`include "assert_macros.svh"

module ptt_dpath #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ptt_pkg::IN_W-1:0] s_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [15:0]              cfg_data,
    input  ptt_pkg::ptt_cmd_t        cmd,
    output ptt_pkg::ptt_stat_t       st,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ptt_pkg::OUT_W-1:0] m_tdata,
    output logic [0:0]               m_tuser,
    output logic                     m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    // Item and configuration registers
    logic [2:0]        op_reg;
    logic [3:0]        idx_reg;
    logic [15:0]       dms_reg;
    logic [15:0]       pms_reg;
    logic [15:0]       tps_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  walk_reg;
    logic [CNT_W-1:0]  walk_next;
    logic [IDX_W-1:0]  walk_slot;
    logic [IDX_W-1:0]  idx_slot;
    logic              walk_end;

    // Slot tables
    logic [15:0]       sd_mem [SLOTS];
    logic [15:0]       cd_mem [SLOTS];
    logic [15:0]       rl_mem [SLOTS];
    logic [15:0]       sd_rd_reg;
    logic [15:0]       cd_rd_reg;
    logic [15:0]       rl_rd_reg;
    logic [SLOTS-1:0]  ready_reg;
    logic [SLOTS-1:0]  en_reg;
    logic [SLOTS-1:0]  above;

    // Tick write-back stage
    logic              wb_vld_reg;
    logic [IDX_W-1:0]  wb_idx_reg;
    logic              sd_nz;
    logic [15:0]       cd_dec;

    // Table write port
    logic [IDX_W-1:0]  wr_addr;
    logic              sd_we;
    logic              cd_we;
    logic              rl_we;
    logic [15:0]       sd_wd;
    logic [15:0]       cd_wd;
    logic [15:0]       rl_wd;

    // Conversion
    logic [15:0]       conv_ms;
    logic [15:0]       conv_ticks;
    logic [15:0]       delay_ticks_reg;

    // Result register
    logic              out_vld_reg;
    logic [1:0]        out_status_reg;
    logic [3:0]        out_slot_reg;
    logic              out_disp_reg;
    logic              out_last_reg;
    logic [3:0]        out_slot_sel;
    logic              out_free;

    assign walk_slot = IDX_W'(walk_reg);
    assign idx_slot  = IDX_W'(idx_reg);
    assign walk_end  = walk_reg >= count_reg;
    assign cfg_ready = 1'b1;

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            op_reg  <= s_tdata[2:0];
            idx_reg <= s_tdata[6:3];
            dms_reg <= s_tdata[22:7];
            pms_reg <= s_tdata[38:23];
        end
    end

    // Hold the tick rate, count occupied slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg   <= ptt_pkg::TPS_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                tps_reg <= cfg_data;
            if (cmd.add_wr)
                count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Slot walker
    always_comb
    begin
        walk_next = walk_reg;
        if (cmd.walk_load)
        begin
            unique case (cmd.walk_src)
                ptt_pkg::WSRC_COUNT: walk_next = count_reg;
                ptt_pkg::WSRC_IDX:   walk_next = CNT_W'(idx_reg);
                default:             walk_next = '0;
            endcase
        end
        else if (cmd.walk_inc)
        begin
            walk_next = walk_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg   <= '0;
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            walk_reg   <= walk_next;
            wb_vld_reg <= cmd.tick_step && !walk_end;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_idx_reg <= walk_slot;
    end

    // Convert delay or period
    assign conv_ms = cmd.conv_period ? pms_reg : dms_reg;

    ptt_ms2tick u_ms2tick (
        .clk   (clk),
        .ms    (conv_ms),
        .tps   (tps_reg),
        .ticks (conv_ticks)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.delay_cap)
            delay_ticks_reg <= conv_ticks;
    end

    // Select table writes
    assign sd_nz   = sd_rd_reg != 16'd0;
    assign cd_dec  = cd_rd_reg - 16'd1;
    assign wr_addr = wb_vld_reg ? wb_idx_reg : walk_slot;

    always_comb
    begin
        sd_we = 1'b0;
        cd_we = 1'b0;
        rl_we = 1'b0;
        sd_wd = sd_rd_reg - 16'd1;
        cd_wd = cd_dec;
        rl_wd = conv_ticks;
        priority if (wb_vld_reg)
        begin
            sd_we = sd_nz;
            cd_we = !sd_nz;
        end
        else if (cmd.add_wr)
        begin
            sd_we = 1'b1;
            cd_we = 1'b1;
            rl_we = 1'b1;
            sd_wd = delay_ticks_reg;
            cd_wd = conv_ticks;
        end
        else if (cmd.per_wr)
        begin
            rl_we = 1'b1;
        end
        else if (cmd.disp_wr)
        begin
            cd_we = 1'b1;
            cd_wd = rl_rd_reg;
        end
        else
        begin
            // Hold the tables
            sd_we = 1'b0;
            cd_we = 1'b0;
            rl_we = 1'b0;
        end
    end

    // Table memories, read at the walker with registered data
    always_ff @(posedge clk)
    begin
        if (sd_we)
            sd_mem[wr_addr] <= sd_wd;
        if (cd_we)
            cd_mem[wr_addr] <= cd_wd;
        if (rl_we)
            rl_mem[wr_addr] <= rl_wd;
        sd_rd_reg <= sd_mem[walk_slot];
        cd_rd_reg <= cd_mem[walk_slot];
        rl_rd_reg <= rl_mem[walk_slot];
    end

    // Ready and enable flags
    always_ff @(posedge clk)
    begin
        if (wb_vld_reg && !sd_nz && cd_dec == 16'd0)
            ready_reg[wb_idx_reg] <= 1'b1;
        else if (cmd.add_wr || cmd.disp_wr)
            ready_reg[walk_slot] <= 1'b0;

        if (cmd.add_wr)
            en_reg[walk_slot] <= 1'b1;
        else if (cmd.en_set)
            en_reg[idx_slot] <= 1'b1;
        else if (cmd.en_clr)
            en_reg[idx_slot] <= 1'b0;
    end

    // Occupied slots past the walker
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
            above[j] = (CNT_W'(j) > walk_reg) && (CNT_W'(j) < count_reg);
    end

    // Result register
    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        unique case (cmd.out_slot_sel)
            ptt_pkg::SLOT_IDX:  out_slot_sel = idx_reg;
            ptt_pkg::SLOT_WALK: out_slot_sel = 4'(walk_reg);
            default:            out_slot_sel = 4'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.out_load)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_slot_reg   <= out_slot_sel;
            out_disp_reg   <= cmd.out_disp;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_slot_reg, out_status_reg};
    assign m_tuser  = out_disp_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    assign st.op        = op_reg;
    assign st.full      = count_reg == CNT_W'(SLOTS);
    assign st.empty     = count_reg == '0;
    assign st.idx_bad   = CMP_W'(idx_reg) >= CMP_W'(count_reg);
    assign st.walk_end  = walk_end;
    assign st.hit       = !walk_end && ready_reg[walk_slot] && en_reg[walk_slot];
    assign st.more_hits = |(ready_reg & en_reg & above);
    assign st.tick_done = walk_end && !wb_vld_reg;
    assign st.out_free  = out_free;

    `PTT_ASSERT(a_count_range, clk, rst_n, count_reg <= CNT_W'(SLOTS), "slot count out of range")
    `PTT_NEVER(a_load_busy, clk, rst_n, cmd.out_load && !out_free, "result overwritten")
    `PTT_ASSERT(a_count_by_add, clk, rst_n, (count_reg != $past(count_reg)) |-> $past(cmd.add_wr), "count changed without add")
    `PTT_ASSERT(a_wb_from_tick, clk, rst_n, wb_vld_reg |-> $past(cmd.tick_step), "write-back outside tick walk")

endmodule

// ----- rtl/ptt_ctrl.sv -----
// Controller: sequences tick walks, adds, slot updates and dispatch scans.
module ptt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ptt_pkg::ptt_stat_t st,
    output ptt_pkg::ptt_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_TICK  = 4'd2;
    localparam logic [3:0] S_DSCAN = 4'd3;
    localparam logic [3:0] S_DLOAD = 4'd4;
    localparam logic [3:0] S_CV_D  = 4'd5;
    localparam logic [3:0] S_CV_P  = 4'd6;
    localparam logic [3:0] S_CV_W  = 4'd7;
    localparam logic [3:0] S_CV_WR = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    logic [3:0]                       state_reg;
    logic [3:0]                       state_next;
    logic [1:0]                       rsp_status_reg;
    logic [1:0]                       rsp_status_next;
    logic [1:0]                       rsp_sel_reg;
    logic [1:0]                       rsp_sel_next;
    logic [ptt_pkg::DISP_CNT_W-1:0]   disp_cnt_reg;
    logic [ptt_pkg::DISP_CNT_W-1:0]   disp_cnt_next;
    logic                             cnt_max;

    assign s_tready = state_reg == S_IDLE;
    assign cnt_max  = disp_cnt_reg == ptt_pkg::DISP_CNT_W'(ptt_pkg::MAX_RESULTS);

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        rsp_status_next = rsp_status_reg;
        rsp_sel_next    = rsp_sel_reg;
        disp_cnt_next   = disp_cnt_reg;
        cmd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.item_load = s_tvalid;
                if (s_tvalid)
                    state_next = S_DEC;
            end

            S_DEC:
            begin
                rsp_status_next = ptt_pkg::ST_OK;
                rsp_sel_next    = ptt_pkg::SLOT_ZERO;
                state_next      = S_RESP;
                unique case (st.op)
                    ptt_pkg::OP_TICK:
                    begin
                        cmd.walk_load = 1'b1;
                        cmd.walk_src  = ptt_pkg::WSRC_ZERO;
                        state_next    = S_TICK;
                    end
                    ptt_pkg::OP_ADD:
                    begin
                        if (st.full)
                        begin
                            rsp_status_next = ptt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.walk_load = 1'b1;
                            cmd.walk_src  = ptt_pkg::WSRC_COUNT;
                            state_next    = S_CV_D;
                        end
                    end
                    ptt_pkg::OP_ENABLE, ptt_pkg::OP_DISABLE, ptt_pkg::OP_SETP:
                    begin
                        rsp_sel_next = ptt_pkg::SLOT_IDX;
                        priority if (st.empty)
                        begin
                            rsp_status_next = ptt_pkg::ST_EMPTY;
                        end
                        else if (st.idx_bad)
                        begin
                            rsp_status_next = ptt_pkg::ST_NOSLOT;
                        end
                        else if (st.op == ptt_pkg::OP_SETP)
                        begin
                            cmd.walk_load = 1'b1;
                            cmd.walk_src  = ptt_pkg::WSRC_IDX;
                            state_next    = S_CV_D;
                        end
                        else
                        begin
                            cmd.en_set = st.op == ptt_pkg::OP_ENABLE;
                            cmd.en_clr = st.op == ptt_pkg::OP_DISABLE;
                        end
                    end
                    ptt_pkg::OP_DISPATCH:
                    begin
                        cmd.walk_load = 1'b1;
                        cmd.walk_src  = ptt_pkg::WSRC_ZERO;
                        disp_cnt_next = '0;
                        state_next    = S_DSCAN;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            // Walk occupied slots through the read and write-back stages
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                cmd.walk_inc  = !st.walk_end;
                if (st.tick_done)
                begin
                    rsp_status_next = ptt_pkg::ST_OK;
                    rsp_sel_next    = ptt_pkg::SLOT_ZERO;
                    state_next      = S_RESP;
                end
            end

            // Look for the next ready and enabled slot
            S_DSCAN:
            begin
                priority if (st.walk_end || cnt_max)
                begin
                    rsp_status_next = ptt_pkg::ST_OK;
                    rsp_sel_next    = ptt_pkg::SLOT_ZERO;
                    state_next      = (disp_cnt_reg == '0) ? S_RESP : S_IDLE;
                end
                else if (st.hit)
                begin
                    state_next = S_DLOAD;
                end
                else
                begin
                    cmd.walk_inc = 1'b1;
                end
            end

            // Reload the countdown and release the slot
            S_DLOAD:
            begin
                if (st.out_free)
                begin
                    cmd.disp_wr      = 1'b1;
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = ptt_pkg::ST_OK;
                    cmd.out_slot_sel = ptt_pkg::SLOT_WALK;
                    cmd.out_disp     = 1'b1;
                    cmd.out_last     = !st.more_hits ||
                        disp_cnt_reg == ptt_pkg::DISP_CNT_W'(ptt_pkg::MAX_RESULTS - 1);
                    cmd.walk_inc     = 1'b1;
                    disp_cnt_next    = disp_cnt_reg + ptt_pkg::DISP_CNT_W'(1);
                    state_next       = S_DSCAN;
                end
            end

            S_CV_D:
            begin
                cmd.conv_period = 1'b0;
                state_next      = S_CV_P;
            end

            S_CV_P:
            begin
                cmd.conv_period = 1'b1;
                state_next      = S_CV_W;
            end

            S_CV_W:
            begin
                cmd.delay_cap = 1'b1;
                state_next    = S_CV_WR;
            end

            // Write the converted values to the table
            S_CV_WR:
            begin
                rsp_status_next = ptt_pkg::ST_OK;
                if (st.op == ptt_pkg::OP_ADD)
                begin
                    cmd.add_wr   = 1'b1;
                    rsp_sel_next = ptt_pkg::SLOT_WALK;
                end
                else
                begin
                    cmd.per_wr   = 1'b1;
                    rsp_sel_next = ptt_pkg::SLOT_IDX;
                end
                state_next = S_RESP;
            end

            // Hand the single result to the result register
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = rsp_status_reg;
                    cmd.out_slot_sel = rsp_sel_reg;
                    cmd.out_disp     = 1'b0;
                    cmd.out_last     = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_status_reg <= ptt_pkg::ST_OK;
            rsp_sel_reg    <= ptt_pkg::SLOT_ZERO;
            disp_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_status_reg <= rsp_status_next;
            rsp_sel_reg    <= rsp_sel_next;
            disp_cnt_reg   <= disp_cnt_next;
        end
    end

endmodule

// ----- rtl/periodic_task_timer_table_unit.sv -----
// Enable, disable, full add and undefined ops go from decode to the result load; add and set
// period pass through the delay and period conversion states and the table write; tick walks
// the occupied slots through read and write-back; dispatch scans one slot a cycle and releases
// each hit slot in a load state that waits for a free result register. One item is in work at
// a time and the next is accepted once the controller is back in idle.
// Reset clears control state and the slot count and sets the tick rate to 1000; no clearing pass.
module periodic_task_timer_table_unit #(
    parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ptt_pkg::IN_W-1:0]  s_tdata,   // op[2:0], task_index[6:3], delay_ms[22:7],
                                                 // period_ms[38:23]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ptt_pkg::OUT_W-1:0] m_tdata,   // status[1:0], task_slot[5:2]
    output logic [0:0]                m_tuser,   // dispatched[0]
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_data   // tick_rate
);

    ptt_pkg::ptt_cmd_t  cmd;
    ptt_pkg::ptt_stat_t st;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ptt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
